// ===== hw/rtl/see_pkg.sv =====
package see_pkg;

  localparam int StackDepth = 16;
  localparam int SpW = $clog2(StackDepth);
  localparam int CntW = $clog2(StackDepth + 1);

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DIV0  = 2'd1;
  localparam logic [1:0] ST_UNDER = 2'd2;
  localparam logic [1:0] ST_OVER  = 2'd3;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_MOD = 3'd4,
    OP_POW = 3'd5
  } op_t;

  typedef struct packed {
    logic       is_digit;
    logic       is_op;
    op_t        op;
    logic [3:0] digit;
    logic       last;
  } cmd_t;

endpackage

// ===== hw/rtl/see_front.sv =====
module see_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  output logic          in_full,
  input  logic [7:0]    in_symbol,
  input  logic          in_last,
  output see_pkg::cmd_t q_cmd,
  output logic          q_valid,
  input  logic          q_pop
);
  import see_pkg::*;

  localparam int QDepth = 4;

  cmd_t       mem_r [QDepth];
  logic [1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  cmd_t       cls;
  logic       do_push, do_pop;

  always_comb begin
    cls = '0;
    cls.last = in_last;
    cls.digit = in_symbol[3:0];
    cls.is_digit = (in_symbol >= 8'h30) && (in_symbol <= 8'h39);
    cls.is_op = 1'b1;
    cls.op = OP_ADD;
    case (in_symbol)
      8'h2b: cls.op = OP_ADD;
      8'h2d: cls.op = OP_SUB;
      8'h2a: cls.op = OP_MUL;
      8'h2f: cls.op = OP_DIV;
      8'h25: cls.op = OP_MOD;
      8'h5e: cls.op = OP_POW;
      default: cls.is_op = 1'b0;
    endcase
  end

  assign in_full = (cnt_r == 3'(QDepth));
  assign q_valid = (cnt_r != 3'd0);
  assign q_cmd = mem_r[rp_r];
  assign do_push = in_push && !in_full;
  assign do_pop = q_pop && q_valid;

  always_comb begin
    wp_nxt = do_push ? wp_r + 2'd1 : wp_r;
    rp_nxt = do_pop ? rp_r + 2'd1 : rp_r;
    cnt_nxt = cnt_r + 3'(do_push) - 3'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) mem_r[wp_r] <= cls;
  end
endmodule

// ===== hw/rtl/see_divider.sv =====
module see_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quot,
  output logic [31:0] rem
);
  logic [31:0] q_r, q_nxt, r_r, r_nxt, d_r;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [32:0] trial;

  assign trial = {r_r, q_r[31]} - {1'b0, d_r};
  assign quot = q_r;
  assign rem = r_r;
  assign done = busy_r && (cnt_r == 6'd32);

  always_comb begin
    q_nxt = q_r;
    r_nxt = r_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      q_nxt = dividend;
      r_nxt = '0;
      cnt_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (cnt_r == 6'd32) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r + 6'd1;
        if (!trial[32]) begin
          r_nxt = trial[31:0];
          q_nxt = {q_r[30:0], 1'b1};
        end else begin
          r_nxt = {r_r[30:0], q_r[31]};
          q_nxt = {q_r[30:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    r_r <= r_nxt;
    if (start) d_r <= divisor;
  end
endmodule

// ===== hw/rtl/see_back.sv =====
module see_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          mode,
  input  see_pkg::cmd_t q_cmd,
  input  logic          q_valid,
  output logic          q_pop,
  output logic          out_empty,
  input  logic          out_pop,
  output logic [31:0]   out_value,
  output logic [1:0]    out_status
);
  import see_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_RD1  = 8'b00000010,
    S_RD2  = 8'b00000100,
    S_EXEC = 8'b00001000,
    S_DIV  = 8'b00010000,
    S_POW  = 8'b00100000,
    S_WB   = 8'b01000000,
    S_EMIT = 8'b10000000
  } state_t;

  state_t      st_r, st_nxt;
  logic [31:0] stk_r [StackDepth];
  logic [31:0] rd_r;
  logic [SpW-1:0] ra;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [1:0]  err_r, err_nxt;
  cmd_t        cmd_r;
  logic [31:0] a_r, a_nxt, b_r, b_nxt, res_r, res_nxt;
  logic [31:0] base_r, base_nxt, ex_r, ex_nxt;
  logic [31:0] mag_a, mag_b, prod, sq;
  logic        div_start, div_done;
  logic [31:0] dq, dr;
  logic        ov_r, ov_nxt;
  logic [31:0] ov_val_r, ov_val_nxt;
  logic [1:0]  ov_st_r, ov_st_nxt;
  logic        wr_en;
  logic [SpW-1:0] wr_a;
  logic [31:0] wr_d;
  logic [1:0]  fin_err;
  logic        wb_ok_r;

  // divider latches its operands on start, while a_r/b_r are still loading
  assign mag_a = a_nxt[31] ? 32'd0 - a_nxt : a_nxt;
  assign mag_b = b_nxt[31] ? 32'd0 - b_nxt : b_nxt;
  assign prod = res_r * base_r;
  assign sq = base_r * base_r;
  assign out_empty = !ov_r;
  assign out_value = ov_val_r;
  assign out_status = ov_st_r;

  see_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .dividend(mag_a), .divisor(mag_b),
    .done(div_done), .quot(dq), .rem(dr)
  );

  always_comb begin
    ra = SpW'(cnt_r - CntW'(1));
    if (st_r == S_RD1) ra = SpW'(cnt_r - CntW'(2));
  end

  always_comb begin
    st_nxt = st_r;
    cnt_nxt = cnt_r;
    err_nxt = err_r;
    a_nxt = a_r;
    b_nxt = b_r;
    res_nxt = res_r;
    base_nxt = base_r;
    ex_nxt = ex_r;
    ov_nxt = ov_r;
    ov_val_nxt = ov_val_r;
    ov_st_nxt = ov_st_r;
    q_pop = 1'b0;
    div_start = 1'b0;
    wr_en = 1'b0;
    wr_a = SpW'(cnt_r);
    wr_d = {28'd0, cmd_r.digit};
    fin_err = err_r;
    if (ov_r && out_pop) ov_nxt = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_cmd.is_digit) begin
            if (cnt_r >= CntW'(StackDepth)) begin
              if (err_r == ST_OK) err_nxt = ST_OVER;
              st_nxt = S_WB;
            end else begin
              wr_en = 1'b1;
              wr_d = {28'd0, q_cmd.digit};
              cnt_nxt = cnt_r + CntW'(1);
              st_nxt = S_WB;
            end
          end else if (q_cmd.is_op) begin
            if (cnt_r < CntW'(2)) begin
              if (err_r == ST_OK) err_nxt = ST_UNDER;
              st_nxt = S_WB;
            end else begin
              st_nxt = S_RD1;
            end
          end else begin
            st_nxt = S_WB;
          end
        end
      end
      S_RD1: st_nxt = S_RD2;
      S_RD2: begin
        // rd_r holds the entry below the top
        if (mode) b_nxt = rd_r; else a_nxt = rd_r;
        st_nxt = S_EXEC;
      end
      S_EXEC: begin
        // rd_r holds the top, the first pop
        if (mode) a_nxt = rd_r; else b_nxt = rd_r;
        st_nxt = S_WB;
        cnt_nxt = cnt_r - CntW'(1);
      end
      S_DIV: begin
        if (div_done) begin
          if (cmd_r.op == OP_DIV)
            res_nxt = (a_r[31] != b_r[31]) ? 32'd0 - dq : dq;
          else
            res_nxt = a_r[31] ? 32'd0 - dr : dr;
          st_nxt = S_WB;
        end
      end
      S_POW: begin
        if (ex_r == 32'd0) begin
          st_nxt = S_WB;
        end else begin
          if (ex_r[0]) res_nxt = prod;
          base_nxt = sq;
          ex_nxt = {1'b0, ex_r[31:1]};
        end
      end
      S_WB: begin
        if (cmd_r.last) begin
          if (!ov_r || out_pop) st_nxt = S_EMIT;
        end else begin
          st_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (cnt_r == '0) begin
          fin_err = (err_r == ST_OK) ? ST_UNDER : err_r;
          ov_val_nxt = '0;
        end else begin
          // the operator result lands in the stack at the same edge rd_r is read
          ov_val_nxt = wb_ok_r ? res_r : rd_r;
        end
        ov_st_nxt = fin_err;
        ov_nxt = 1'b1;
        cnt_nxt = '0;
        err_nxt = ST_OK;
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase

    // operator dispatch in S_EXEC, while the second operand is still being latched
    if (st_r == S_EXEC) begin
      // operands valid next cycle; compute from a_nxt/b_nxt
      unique case (cmd_r.op)
        OP_ADD: res_nxt = a_nxt + b_nxt;
        OP_SUB: res_nxt = a_nxt - b_nxt;
        OP_MUL: begin
          res_nxt = a_nxt;
          base_nxt = b_nxt;
          ex_nxt = 32'd1;
          st_nxt = S_POW;
        end
        OP_DIV, OP_MOD: begin
          if (b_nxt == 32'd0) begin
            res_nxt = '0;
            if (err_r == ST_OK) err_nxt = ST_DIV0;
          end else begin
            div_start = 1'b1;
            st_nxt = S_DIV;
          end
        end
        OP_POW: begin
          if (b_nxt[31]) begin
            if (a_nxt == 32'd1) res_nxt = 32'd1;
            else if (a_nxt == 32'hffffffff) res_nxt = b_nxt[0] ? 32'hffffffff : 32'd1;
            else res_nxt = '0;
          end else begin
            res_nxt = 32'd1;
            base_nxt = a_nxt;
            ex_nxt = b_nxt;
            st_nxt = S_POW;
          end
        end
        default: res_nxt = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      cnt_r <= '0;
      err_r <= ST_OK;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      cnt_r <= cnt_nxt;
      err_r <= err_nxt;
      ov_r <= ov_nxt;
    end
    if (q_pop) cmd_r <= q_cmd;
    a_r <= a_nxt;
    b_r <= b_nxt;
    base_r <= base_nxt;
    ex_r <= ex_nxt;
    res_r <= res_nxt;
    ov_val_r <= ov_val_nxt;
    ov_st_r <= ov_st_nxt;
    rd_r <= stk_r[ra];
    if (wr_en) stk_r[wr_a] <= wr_d;
    if (st_r == S_WB && cmd_r.is_op && !cmd_r.is_digit && cnt_r != '0
        && wb_ok_r)
      stk_r[SpW'(cnt_r - CntW'(1))] <= res_r;
  end

  // operator writeback is valid only when an operation really ran
  always_ff @(posedge clk) begin
    if (!rst_n) wb_ok_r <= 1'b0;
    else if (st_r == S_EXEC) wb_ok_r <= 1'b1;
    else if (st_r == S_IDLE) wb_ok_r <= 1'b0;
  end
endmodule

// ===== hw/rtl/stack_expression_evaluator.sv =====
// digits and ignored characters go straight to writeback; + and - compute in S_EXEC; * runs through S_POW,
// / and % use a 32-step shift-subtract divider, ^ uses square-and-multiply
// over the exponent bits; the result is registered into the output slot from S_EMIT after writeback
// throughput: one item at a time in the execution engine, 4-entry input queue
// synchronous active-low reset clears stack count, status, queues and mode
module stack_expression_evaluator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_symbol,
  input  logic        in_last,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] out_value,
  output logic [1:0]  out_status,
  input  logic        cfg_we,
  input  logic        cfg_notation_mode
);
  import see_pkg::*;

  cmd_t q_cmd;
  logic q_valid, q_pop, mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) mode_r <= 1'b0;
    else if (cfg_we) mode_r <= cfg_notation_mode;
  end

  see_front u_front (
    .clk(clk), .rst_n(rst_n), .in_push(push), .in_full(full),
    .in_symbol(in_symbol), .in_last(in_last),
    .q_cmd(q_cmd), .q_valid(q_valid), .q_pop(q_pop)
  );

  see_back u_back (
    .clk(clk), .rst_n(rst_n), .mode(mode_r),
    .q_cmd(q_cmd), .q_valid(q_valid), .q_pop(q_pop),
    .out_empty(empty), .out_pop(pop),
    .out_value(out_value), .out_status(out_status)
  );
endmodule
